// ===== src/qepi_pkg.sv =====
package qepi_pkg;

  // Fixed-point unity for the Q1.16 curve value.
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  // Configuration register word indexes.
  localparam logic REG_CURVE_MODE = 1'b0;

  // Easing curve selection.
  typedef enum logic [1:0] {
    CURVE_LINEAR = 2'd0,
    CURVE_IN     = 2'd1,
    CURVE_OUT    = 2'd2,
    CURVE_IN_OUT = 2'd3
  } curve_mode_t;

  // One incoming vertex request.
  typedef struct packed {
    logic [15:0]        time_now;
    logic signed [15:0] from_x;
    logic signed [15:0] from_y;
    logic signed [15:0] to_x;
    logic signed [15:0] to_y;
    logic               last_point;
  } in_req_t;

  // One interpolated point.
  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic               end_of_path;
  } out_rsp_t;

  // Vertex coordinates carried alongside the time math.
  typedef struct packed {
    logic signed [15:0] from_x;
    logic signed [15:0] from_y;
    logic signed [15:0] to_x;
    logic signed [15:0] to_y;
    logic               last_point;
  } vtx_t;

  // Progress stage result.
  typedef struct packed {
    logic [15:0] p;
    logic        at_end;
    vtx_t        vtx;
  } prog_t;

  // Curve stage result.
  typedef struct packed {
    logic [16:0]        f;
    logic signed [15:0] from_x;
    logic signed [15:0] from_y;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic               last_point;
  } crv_t;

endpackage

// ===== src/qepi_progress.sv =====
module qepi_progress import qepi_pkg::*; #(
  parameter int TIME_BITS = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    up_valid,
  output logic    up_stall,
  input  in_req_t up,
  output logic    dn_valid,
  input  logic    dn_stall,
  output prog_t   dn
);

  localparam int unsigned TMAX = (1 << TIME_BITS) - 1;
  localparam int NW = TIME_BITS + 16;
  localparam int NT = (NW + TIME_BITS - 1) / TIME_BITS;
  localparam int NC = NT + 1;
  localparam int RW = TIME_BITS + 18;

  logic                 a_valid;
  logic                 b_valid;
  logic                 a_en;
  logic                 b_en;
  logic [NW-1:0]        t_wide;
  logic [TIME_BITS-1:0] t_in;
  logic [NW-1:0]        n_in;
  logic [NW-1:0]        s_sum;
  logic [TIME_BITS-1:0] a_t;
  logic [16:0]          a_s;
  logic                 a_end;
  vtx_t                 a_vtx;
  logic [NW-1:0]        n_b;
  logic [RW-1:0]        r_b;
  logic [16:0]          q_b;

  // Stage enables: a stage moves when it is empty or its successor moves.
  assign b_en     = !b_valid || !dn_stall;
  assign a_en     = !a_valid || b_en;
  assign up_stall = !a_en;
  assign dn_valid = b_valid;

  // Mask the time to the configured width and scale it to Q16.
  assign t_wide = NW'(up.time_now);
  assign t_in   = t_wide[TIME_BITS-1:0];
  assign n_in   = {t_in, 16'b0};

  // Estimate of n / (2^k - 1) as the series n/2^k + n/2^2k + ...
  always_comb begin
    s_sum = '0;
    for (int i = 1; i <= NT; i++) begin
      s_sum = s_sum + (n_in >> (i * TIME_BITS));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (a_en) begin
        a_valid <= up_valid;
      end
      if (b_en) begin
        b_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_en) begin
      a_t   <= t_in;
      a_s   <= s_sum[16:0];
      a_end <= (t_in == TIME_BITS'(TMAX));
      a_vtx <= '{from_x: up.from_x, from_y: up.from_y, to_x: up.to_x,
                 to_y: up.to_y, last_point: up.last_point};
    end
  end

  // The estimate is low by at most a few units; the remainder fixes it.
  assign n_b = {a_t, 16'b0};
  assign r_b = RW'(n_b) + RW'(a_s) - (RW'(a_s) << TIME_BITS);

  always_comb begin
    q_b = a_s;
    for (int j = 1; j <= NC; j++) begin
      if (r_b >= RW'(j * TMAX)) begin
        q_b = q_b + 17'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_en) begin
      dn.p      <= q_b[15:0];
      dn.at_end <= a_end;
      dn.vtx    <= a_vtx;
    end
  end

endmodule

// ===== src/qepi_curve.sv =====
module qepi_curve import qepi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  curve_mode_t mode,
  input  logic        up_valid,
  output logic        up_stall,
  input  prog_t       up,
  output logic        dn_valid,
  input  logic        dn_stall,
  output crv_t        dn
);

  logic               c_valid;
  logic               d_valid;
  logic               e_valid;
  logic               c_en;
  logic               d_en;
  logic               e_en;
  logic [16:0]        x_in;
  logic [33:0]        sq_c;
  logic [33:0]        sq_d;
  logic [16:0]        f_e;

  // Stage C registers.
  logic [16:0]        c_x2;
  logic [15:0]        c_p;
  logic               c_end;
  logic signed [15:0] c_from_x;
  logic signed [15:0] c_from_y;
  logic signed [16:0] c_dx;
  logic signed [16:0] c_dy;
  logic               c_last;

  // Stage D registers.
  logic [16:0]        d_x4;
  logic [15:0]        d_p;
  logic               d_end;
  logic signed [15:0] d_from_x;
  logic signed [15:0] d_from_y;
  logic signed [16:0] d_dx;
  logic signed [16:0] d_dy;
  logic               d_last;

  assign e_en     = !e_valid || !dn_stall;
  assign d_en     = !d_valid || e_en;
  assign c_en     = !c_valid || d_en;
  assign up_stall = !c_en;
  assign dn_valid = e_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      e_valid <= 1'b0;
    end else begin
      if (c_en) begin
        c_valid <= up_valid;
      end
      if (d_en) begin
        d_valid <= c_valid;
      end
      if (e_en) begin
        e_valid <= d_valid;
      end
    end
  end

  // Base of the fourth power for the selected curve.
  always_comb begin
    case (mode)
      CURVE_OUT: x_in = ONE_Q16 - {1'b0, up.p};
      CURVE_IN_OUT: begin
        if (!up.p[15]) begin
          x_in = {up.p, 1'b0};
        end else begin
          x_in = 17'(18'd131072 - {1'b0, up.p, 1'b0});
        end
      end
      default: x_in = {1'b0, up.p};
    endcase
  end

  // Stage C: square of the base; change terms.
  assign sq_c = 34'(x_in) * 34'(x_in);

  always_ff @(posedge clk) begin
    if (c_en) begin
      c_x2     <= sq_c[32:16];
      c_p      <= up.p;
      c_end    <= up.at_end;
      c_from_x <= up.vtx.from_x;
      c_from_y <= up.vtx.from_y;
      c_dx     <= 17'(up.vtx.to_x) - 17'(up.vtx.from_x);
      c_dy     <= 17'(up.vtx.to_y) - 17'(up.vtx.from_y);
      c_last   <= up.vtx.last_point;
    end
  end

  // Stage D: fourth power.
  assign sq_d = 34'(c_x2) * 34'(c_x2);

  always_ff @(posedge clk) begin
    if (d_en) begin
      d_x4     <= sq_d[32:16];
      d_p      <= c_p;
      d_end    <= c_end;
      d_from_x <= c_from_x;
      d_from_y <= c_from_y;
      d_dx     <= c_dx;
      d_dy     <= c_dy;
      d_last   <= c_last;
    end
  end

  // Stage E: curve value; the final time position lands exactly on unity.
  always_comb begin
    case (mode)
      CURVE_IN:  f_e = d_x4;
      CURVE_OUT: f_e = ONE_Q16 - d_x4;
      CURVE_IN_OUT: begin
        if (!d_p[15]) begin
          f_e = d_x4 >> 1;
        end else begin
          f_e = ONE_Q16 - (d_x4 >> 1);
        end
      end
      default: f_e = {1'b0, d_p};
    endcase
    if (d_end) begin
      f_e = ONE_Q16;
    end
  end

  always_ff @(posedge clk) begin
    if (e_en) begin
      dn.f          <= f_e;
      dn.from_x     <= d_from_x;
      dn.from_y     <= d_from_y;
      dn.dx         <= d_dx;
      dn.dy         <= d_dy;
      dn.last_point <= d_last;
    end
  end

endmodule

// ===== src/qepi_blend.sv =====
module qepi_blend import qepi_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     up_valid,
  output logic     up_stall,
  input  crv_t     up,
  output logic     dn_valid,
  input  logic     dn_stall,
  output out_rsp_t dn
);

  logic               f_valid;
  logic               g_valid;
  logic               f_en;
  logic               g_en;
  logic signed [17:0] f_signed;
  logic signed [34:0] f_prod_x;
  logic signed [34:0] f_prod_y;
  logic signed [15:0] f_from_x;
  logic signed [15:0] f_from_y;
  logic               f_last;
  logic signed [34:0] adj_x;
  logic signed [34:0] adj_y;
  logic signed [34:0] c_x;
  logic signed [34:0] c_y;

  assign g_en     = !g_valid || !dn_stall;
  assign f_en     = !f_valid || g_en;
  assign up_stall = !f_en;
  assign dn_valid = g_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
      g_valid <= 1'b0;
    end else begin
      if (f_en) begin
        f_valid <= up_valid;
      end
      if (g_en) begin
        g_valid <= f_valid;
      end
    end
  end

  // Stage F: scale the change by the curve value.
  assign f_signed = signed'({1'b0, up.f});

  always_ff @(posedge clk) begin
    if (f_en) begin
      f_prod_x <= 35'(up.dx) * 35'(f_signed);
      f_prod_y <= 35'(up.dy) * 35'(f_signed);
      f_from_x <= up.from_x;
      f_from_y <= up.from_y;
      f_last   <= up.last_point;
    end
  end

  // Stage G: drop the fraction toward zero and add the start point.
  assign adj_x = f_prod_x + (f_prod_x[34] ? 35'sd65535 : 35'sd0);
  assign adj_y = f_prod_y + (f_prod_y[34] ? 35'sd65535 : 35'sd0);
  assign c_x   = adj_x >>> 16;
  assign c_y   = adj_y >>> 16;

  always_ff @(posedge clk) begin
    if (g_en) begin
      dn.point_x     <= f_from_x + signed'(c_x[15:0]);
      dn.point_y     <= f_from_y + signed'(c_y[15:0]);
      dn.end_of_path <= f_last;
    end
  end

endmodule

// ===== src/quartic_easing_point_interpolator.sv =====
// Channel  Signals                       Moves
// -------  ----------------------------  ---------------------------------
// req      req_valid, req_stall, req     one vertex request with its time
// rsp      rsp_valid, rsp_stall, rsp     one interpolated point
// cfg      psel, penable, pwrite, paddr  curve_mode register, APB style
//
// Seven register stages: two for the progress division by 2^TIME_BITS - 1,
// three for the fourth power and curve value (a squaring in each of the first
// two), two for the scaling multiply and final add. One request is taken every
// cycle while req_stall is low. Each stage holds its own valid bit and
// moves when it is empty or the next stage moves, so a stall on rsp fills
// the bubbles before req_stall rises. Synchronous reset clears all valid
// bits and sets curve_mode to linear.
module quartic_easing_point_interpolator import qepi_pkg::*; #(
  parameter int TIME_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        req_valid,
  output logic        req_stall,
  input  in_req_t     req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output out_rsp_t    rsp
);

  curve_mode_t curve_mode;
  logic        prog_valid;
  logic        prog_stall;
  prog_t       prog;
  logic        crv_valid;
  logic        crv_stall;
  crv_t        crv;

  // Configuration register.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_mode <= CURVE_LINEAR;
    end else if (psel && penable && pwrite && (paddr[2] == REG_CURVE_MODE)) begin
      curve_mode <= curve_mode_t'(pwdata[1:0]);
    end
  end

  assign prdata = (paddr[2] == REG_CURVE_MODE) ? {30'b0, curve_mode} : 32'b0;

  qepi_progress #(
    .TIME_BITS (TIME_BITS)
  ) u_progress (
    .clk      (clk),
    .rst      (rst),
    .up_valid (req_valid),
    .up_stall (req_stall),
    .up       (req),
    .dn_valid (prog_valid),
    .dn_stall (prog_stall),
    .dn       (prog)
  );

  qepi_curve u_curve (
    .clk      (clk),
    .rst      (rst),
    .mode     (curve_mode),
    .up_valid (prog_valid),
    .up_stall (prog_stall),
    .up       (prog),
    .dn_valid (crv_valid),
    .dn_stall (crv_stall),
    .dn       (crv)
  );

  qepi_blend u_blend (
    .clk      (clk),
    .rst      (rst),
    .up_valid (crv_valid),
    .up_stall (crv_stall),
    .up       (crv),
    .dn_valid (rsp_valid),
    .dn_stall (rsp_stall),
    .dn       (rsp)
  );

endmodule
